/* sv/rss_pkg.sv */
package rss_pkg;

    // field widths
    localparam int COORD_W     = 16;
    localparam int KIND_W      = 3;
    localparam int TDATA_W     = 4 * COORD_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = COORD_W;
    localparam int QUEUE_DEPTH = 4;

    // bit positions in the piece mask, in emission order
    localparam int PB_INTER  = 0;
    localparam int PB_TILE   = 1;
    localparam int PB_TOP    = 2;
    localparam int PB_BOTTOM = 3;
    localparam int PB_LEFT   = 4;
    localparam int PB_RIGHT  = 5;
    localparam int MASK_W    = 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_TILE   = 3'd0,
        KIND_INTER  = 3'd1,
        KIND_TOP    = 3'd2,
        KIND_BOTTOM = 3'd3,
        KIND_LEFT   = 3'd4,
        KIND_RIGHT  = 3'd5
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CLIP_UL_X  = 3'd0,
        REG_CLIP_UL_Y  = 3'd1,
        REG_CLIP_LR_X  = 3'd2,
        REG_CLIP_LR_Y  = 3'd3,
        REG_EMIT_INTER = 3'd4
    } t_cfg_reg;

    // one classified tile: its corners, the clip corners and the pieces to emit
    typedef struct packed {
        logic signed [COORD_W-1:0] ax0;
        logic signed [COORD_W-1:0] ay0;
        logic signed [COORD_W-1:0] ax1;
        logic signed [COORD_W-1:0] ay1;
        logic signed [COORD_W-1:0] bx0;
        logic signed [COORD_W-1:0] by0;
        logic signed [COORD_W-1:0] bx1;
        logic signed [COORD_W-1:0] by1;
        logic [MASK_W-1:0]         mask;
    } t_job;

    typedef struct packed {
        logic signed [COORD_W-1:0] ul_x;
        logic signed [COORD_W-1:0] ul_y;
        logic signed [COORD_W-1:0] lr_x;
        logic signed [COORD_W-1:0] lr_y;
        t_kind                     kind;
        logic                      last;
    } t_piece;

    function automatic logic signed [COORD_W-1:0] smax(
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [COORD_W-1:0] smin(
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

/* sv/rect_subtract_splitter_unit.sv */
// channel  | dir | signals                              | contents
// s_axis   | in  | tvalid, tready, tdata[63:0]          | one tile rectangle
// m_axis   | out | tvalid, tready, tdata, tuser, tlast  | one piece, kind, last of tile
// cfg      | in  | we, addr[2:0], wdata[15:0]           | clip corners, intersection mode
//
// a tile is classified in the cycle it is accepted and queued; a tile that gives no
// piece is dropped there and never reaches the back end
// the back end emits one piece per cycle while m_axis is not stalled, one to five pieces
// per tile; tiles are taken every cycle while the queue has room
// a tile reaches m_axis through the queue, the back-end tile register and the output reg
// reset is synchronous, active low; it empties the queue and loads the clip reset values
// tile input stalls only when the queue is full; the output register decouples m_axis
module rect_subtract_splitter_unit #(
    parameter int QUEUE_DEPTH = rss_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tile_ul_x, tile_ul_y, tile_lr_x, tile_lr_y (16 bits each)
    input  logic [rss_pkg::TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // piece_ul_x, piece_ul_y, piece_lr_x, piece_lr_y (16 bits each)
    output logic [rss_pkg::TDATA_W-1:0]     o_m_axis_tdata,
    // piece_kind
    output logic [rss_pkg::KIND_W-1:0]      o_m_axis_tuser,
    output logic                            o_m_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic                            i_cfg_we,
    input  logic [rss_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [rss_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    rss_pkg::t_job   front_job, queue_job;
    rss_pkg::t_piece piece;
    logic            keep, full, empty, pop, accept;

    // classification and clip registers
    rss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tile      (i_s_axis_tdata),
        .o_job       (front_job),
        .o_keep      (keep)
    );

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    // queue between classification and piece generation
    rss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && keep),
        .i_data  (front_job),
        .i_pop   (pop),
        .o_data  (queue_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // piece generation
    rss_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (queue_job),
        .i_avail (!empty),
        .o_pop   (pop),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_piece (piece)
    );

    assign o_m_axis_tdata = {piece.lr_y, piece.lr_x, piece.ul_y, piece.ul_x};
    assign o_m_axis_tuser = piece.kind;
    assign o_m_axis_tlast = piece.last;

endmodule

/* sv/rss_front.sv */
module rss_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rss_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rss_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [rss_pkg::TDATA_W-1:0]        i_tile,
    output rss_pkg::t_job                      o_job,
    output logic                               o_keep
);

    logic signed [rss_pkg::COORD_W-1:0] r_clip_ul_x;
    logic signed [rss_pkg::COORD_W-1:0] r_clip_ul_y;
    logic signed [rss_pkg::COORD_W-1:0] r_clip_lr_x;
    logic signed [rss_pkg::COORD_W-1:0] r_clip_lr_y;
    logic                               r_emit_inter;

    logic signed [rss_pkg::COORD_W-1:0] ax0, ay0, ax1, ay1;
    logic signed [rss_pkg::COORD_W-1:0] bx0, by0, bx1, by1;
    logic signed [rss_pkg::COORD_W-1:0] top, bot;
    logic                               tile_ok, hit, covered, inter_ok;
    logic [rss_pkg::MASK_W-1:0]         mask;

    // clip registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_ul_x  <= '0;
            r_clip_ul_y  <= '0;
            r_clip_lr_x  <= '1;
            r_clip_lr_y  <= '1;
            r_emit_inter <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (rss_pkg::t_cfg_reg'(i_cfg_addr))
                rss_pkg::REG_CLIP_UL_X:  r_clip_ul_x  <= i_cfg_wdata;
                rss_pkg::REG_CLIP_UL_Y:  r_clip_ul_y  <= i_cfg_wdata;
                rss_pkg::REG_CLIP_LR_X:  r_clip_lr_x  <= i_cfg_wdata;
                rss_pkg::REG_CLIP_LR_Y:  r_clip_lr_y  <= i_cfg_wdata;
                rss_pkg::REG_EMIT_INTER: r_emit_inter <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // unpack the tile
    assign ax0 = i_tile[0*rss_pkg::COORD_W +: rss_pkg::COORD_W];
    assign ay0 = i_tile[1*rss_pkg::COORD_W +: rss_pkg::COORD_W];
    assign ax1 = i_tile[2*rss_pkg::COORD_W +: rss_pkg::COORD_W];
    assign ay1 = i_tile[3*rss_pkg::COORD_W +: rss_pkg::COORD_W];
    assign bx0 = r_clip_ul_x;
    assign by0 = r_clip_ul_y;
    assign bx1 = r_clip_lr_x;
    assign by1 = r_clip_lr_y;

    // classify the tile against the clip
    always_comb begin
        tile_ok  = (ax1 >= ax0) && (ay1 >= ay0);
        inter_ok = r_emit_inter
                 && (rss_pkg::smin(ax1, bx1) >= rss_pkg::smax(ax0, bx0))
                 && (rss_pkg::smin(ay1, by1) >= rss_pkg::smax(ay0, by0));
        hit      = (ax1 >= bx0) && (bx1 >= ax0) && (ay1 >= by0) && (by1 >= ay0);
        covered  = (ax0 >= bx0) && (ay0 >= by0) && (ax1 <= bx1) && (ay1 <= by1);
        top      = rss_pkg::smax(ay0, by0);
        bot      = rss_pkg::smin(ay1, by1);

        mask                      = '0;
        mask[rss_pkg::PB_INTER]   = inter_ok;
        mask[rss_pkg::PB_TILE]    = !hit;
        mask[rss_pkg::PB_TOP]     = hit && !covered && (by0 > ay0);
        mask[rss_pkg::PB_BOTTOM]  = hit && !covered && (by1 < ay1);
        mask[rss_pkg::PB_LEFT]    = hit && !covered && (top <= bot) && (bx0 > ax0);
        mask[rss_pkg::PB_RIGHT]   = hit && !covered && (top <= bot) && (bx1 < ax1);
        if (!tile_ok) begin
            mask = '0;
        end
    end

    assign o_job  = '{ax0: ax0, ay0: ay0, ax1: ax1, ay1: ay1,
                      bx0: bx0, by0: by0, bx1: bx1, by1: by1, mask: mask};
    assign o_keep = |mask;

endmodule

/* sv/rss_queue.sv */
module rss_queue #(
    parameter int DEPTH = rss_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rss_pkg::t_job i_data,
    input  logic          i_pop,
    output rss_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rss_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);

    // no write into a full queue unless it is also read, no read from an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

/* sv/rss_back.sv */
module rss_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rss_pkg::t_job    i_job,
    input  logic             i_avail,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output rss_pkg::t_piece  o_piece
);

    rss_pkg::t_job               r_job;
    logic [rss_pkg::MASK_W-1:0]  r_mask;
    logic                        r_busy;
    logic                        r_out_valid;
    rss_pkg::t_piece             r_out;

    logic                        free, emit, fin;
    logic [rss_pkg::MASK_W-1:0]  lowest, rest;
    logic signed [rss_pkg::COORD_W-1:0] top, bot;
    rss_pkg::t_piece             piece;

    // pick the next piece of the current tile
    always_comb begin
        free   = !r_out_valid || i_ready;
        emit   = r_busy && free;
        lowest = r_mask & (~r_mask + 1'b1);
        rest   = r_mask & ~lowest;
        fin    = emit && (rest == '0);
        o_pop  = i_avail && (!r_busy || fin);
    end

    // piece corners for the chosen kind
    always_comb begin
        top        = rss_pkg::smax(r_job.ay0, r_job.by0);
        bot        = rss_pkg::smin(r_job.ay1, r_job.by1);
        piece.ul_x = r_job.ax0;
        piece.ul_y = r_job.ay0;
        piece.lr_x = r_job.ax1;
        piece.lr_y = r_job.ay1;
        piece.kind = rss_pkg::KIND_TILE;
        piece.last = (rest == '0);
        if (lowest[rss_pkg::PB_INTER]) begin
            piece.ul_x = rss_pkg::smax(r_job.ax0, r_job.bx0);
            piece.ul_y = top;
            piece.lr_x = rss_pkg::smin(r_job.ax1, r_job.bx1);
            piece.lr_y = bot;
            piece.kind = rss_pkg::KIND_INTER;
        end else if (lowest[rss_pkg::PB_TOP]) begin
            piece.lr_y = r_job.by0 - 1'b1;
            piece.kind = rss_pkg::KIND_TOP;
        end else if (lowest[rss_pkg::PB_BOTTOM]) begin
            piece.ul_y = r_job.by1 + 1'b1;
            piece.kind = rss_pkg::KIND_BOTTOM;
        end else if (lowest[rss_pkg::PB_LEFT]) begin
            piece.ul_y = top;
            piece.lr_x = r_job.bx0 - 1'b1;
            piece.lr_y = bot;
            piece.kind = rss_pkg::KIND_LEFT;
        end else if (lowest[rss_pkg::PB_RIGHT]) begin
            piece.ul_x = r_job.bx1 + 1'b1;
            piece.ul_y = top;
            piece.lr_y = bot;
            piece.kind = rss_pkg::KIND_RIGHT;
        end
    end

    // current tile and its remaining pieces
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mask <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_mask <= i_job.mask;
        end else if (fin) begin
            r_busy <= 1'b0;
            r_mask <= '0;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= piece;
        end
    end

    assign o_valid = r_out_valid;
    assign o_piece = r_out;

    // a busy tile always has a piece left
    a_busy_has_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("busy with an empty piece mask");

    // every emitted piece is a proper rectangle
    a_piece_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.lr_x >= r_out.ul_x) && (r_out.lr_y >= r_out.ul_y)))
        else $error("emitted piece has lr above ul");

endmodule
